// ===== rtl/pgsa_pkg.sv =====
package pgsa_pkg;

    localparam int FUNC_W      = 1;
    localparam int CHANNEL_W   = 4;
    localparam int POINT_W     = 16;
    localparam int GRAD_W      = 32;
    localparam int ACC_W       = 48;
    localparam int STATUS_W    = 2;
    localparam int NPOINTS_W   = 11;
    localparam int NCHANNELS_W = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [FUNC_W-1:0] FN_ACCUM = 1'b0;
    localparam logic [FUNC_W-1:0] FN_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POINT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CHANNEL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SATURATED   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 1'b1;

    localparam logic [NPOINTS_W-1:0]   NUM_POINTS_RST   = 11'd1024;
    localparam logic [NCHANNELS_W-1:0] NUM_CHANNELS_RST = 5'd16;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

// ===== rtl/pgsa_in_if.sv =====
interface pgsa_in_if
    import pgsa_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic [CHANNEL_W-1:0]       channel;
    logic signed [POINT_W-1:0]  point_index;
    logic signed [GRAD_W-1:0]   grad_value;

    modport source (output valid, func, channel, point_index, grad_value, input ready);
    modport sink   (input valid, func, channel, point_index, grad_value, output ready);
endinterface

// ===== rtl/pgsa_out_if.sv =====
interface pgsa_out_if
    import pgsa_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [ACC_W-1:0]    read_value;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

// ===== rtl/pgsa_ram.sv =====
module pgsa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pgsa_sat_add.sv =====
module pgsa_sat_add
    import pgsa_pkg::*;
(
    input  logic signed [ACC_W-1:0]  acc,
    input  logic signed [GRAD_W-1:0] addend,
    output logic signed [ACC_W-1:0]  sum,
    output logic                     sat
);

    logic signed [ACC_W:0] wide;

    assign wide = {acc[ACC_W-1], acc} + (ACC_W+1)'(addend);
    assign sat  = wide[ACC_W] != wide[ACC_W-1];

    always_comb
    begin
        if (!sat)
        begin
            sum = wide[ACC_W-1:0];
        end
        else if (wide[ACC_W])
        begin
            sum = ACC_MIN;
        end
        else
        begin
            sum = ACC_MAX;
        end
    end

endmodule

// ===== rtl/point_gradient_scatter_add.sv =====
// Scatter-add gradient accumulator. Each beat on items with a good channel
// and point adds a signed Q16.16 gradient, saturating, into the Q32.16 entry
// for (channel, point), or reads that entry and clears it; other beats leave
// it alone. Every beat gives exactly one beat on results. An item reads its
// entry from the single-port-write store in S_IDLE; S_LOOKUP, which waits
// while a result is stalled, writes it back updated, and takes no item.
// After reset the store, which holds MAX_CHANNELS * MAX_POINTS entries of
// 48 bits (16384 by default), is zeroed by a clearing pass before the first
// item is taken; configuration writes are accepted throughout. num_points
// and num_channels above the parameters act as the parameter values.
module point_gradient_scatter_add
    import pgsa_pkg::*;
#(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_CHANNELS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pgsa_in_if.sink               items,
    pgsa_out_if.source            results
);

    localparam int DEPTH  = MAX_CHANNELS * MAX_POINTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } state_t;

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       clr_addr_reg, clr_addr_next;
    logic [FUNC_W-1:0]       func_reg, func_next;
    logic signed [GRAD_W-1:0] grad_reg, grad_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [STATUS_W-1:0]     code_reg, code_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [ACC_W-1:0] read_value_reg, read_value_next;
    logic [STATUS_W-1:0]     status_reg, status_next;

    logic [NPOINTS_W-1:0]    num_points_reg;
    logic [NCHANNELS_W-1:0]  num_channels_reg;

    logic [16:0]             np_cfg, np_max, np_eff;
    logic [8:0]              nc_cfg, nc_max, nc_eff;
    logic                    chan_ok, point_ok;
    logic [ADDR_W-1:0]       item_addr;
    logic [31:0]             addr_wide;

    logic                    accept;
    logic                    out_free;
    logic                    ram_we, ram_re;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [ACC_W-1:0]        ram_wdata, ram_rdata;
    logic signed [ACC_W-1:0] sum;
    logic                    sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg   <= NUM_POINTS_RST;
            num_channels_reg <= NUM_CHANNELS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_POINTS:   num_points_reg   <= cfg_data[NPOINTS_W-1:0];
                REG_NUM_CHANNELS: num_channels_reg <= cfg_data[NCHANNELS_W-1:0];
                default:          ;
            endcase
        end
    end

    assign np_cfg   = 17'(num_points_reg);
    assign np_max   = 17'(MAX_POINTS);
    assign np_eff   = (np_cfg > np_max) ? np_max : np_cfg;
    assign nc_cfg   = 9'(num_channels_reg);
    assign nc_max   = 9'(MAX_CHANNELS);
    assign nc_eff   = (nc_cfg > nc_max) ? nc_max : nc_cfg;
    assign chan_ok  = 9'(items.channel) < nc_eff;
    assign point_ok = !items.point_index[POINT_W-1]
                      && (17'(items.point_index[POINT_W-2:0]) < np_eff);

    assign addr_wide = 32'(items.channel) * 32'(MAX_POINTS)
                       + 32'(items.point_index[POINT_W-2:0]);
    assign item_addr = addr_wide[ADDR_W-1:0];

    assign items.ready = (state_reg == S_IDLE);
    assign accept      = items.valid && items.ready;
    assign out_free    = !out_valid_reg || results.ready;

    pgsa_sat_add u_sat_add (
        .acc    (ram_rdata),
        .addend (grad_reg),
        .sum    (sum),
        .sat    (sat)
    );

    pgsa_ram #(
        .WIDTH (ACC_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (item_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        func_next       = func_reg;
        grad_next       = grad_reg;
        addr_next       = addr_reg;
        code_next       = code_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    ram_re    = 1'b1;
                    func_next = items.func;
                    grad_next = items.grad_value;
                    addr_next = item_addr;
                    if (!chan_ok)
                    begin
                        code_next = ST_BAD_CHANNEL;
                    end
                    else if (!point_ok)
                    begin
                        code_next = ST_BAD_POINT;
                    end
                    else
                    begin
                        code_next = ST_OK;
                    end
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (code_reg != ST_OK)
                    begin
                        read_value_next = '0;
                        status_next     = code_reg;
                    end
                    else if (func_reg == FN_READ)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = '0;
                        read_value_next = ram_rdata;
                        status_next     = ST_OK;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = sum;
                        read_value_next = '0;
                        status_next     = sat ? ST_SATURATED : ST_OK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            func_reg       <= FN_ACCUM;
            grad_reg       <= '0;
            addr_reg       <= '0;
            code_reg       <= ST_OK;
            out_valid_reg  <= 1'b0;
            read_value_reg <= '0;
            status_reg     <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            func_reg       <= func_next;
            grad_reg       <= grad_next;
            addr_reg       <= addr_next;
            code_reg       <= code_next;
            out_valid_reg  <= out_valid_next;
            read_value_reg <= read_value_next;
            status_reg     <= status_next;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.read_value = read_value_reg;
    assign results.status     = status_reg;

endmodule

// ===== rtl/pgsa_check.sv =====
module pgsa_check
    import pgsa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [ACC_W-1:0]    out_read_value,
    input logic [STATUS_W-1:0] out_status
);

    // a result beat waiting on the sink stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_read_value) && $stable(out_status))
        else $error("result payload changed while stalled");

    // only an ok read carries a value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ST_OK |-> out_read_value == '0)
        else $error("nonzero value on a rejected or saturated beat");

    // the store is busy with the read-modify-write right after an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted during update cycle");

endmodule

bind point_gradient_scatter_add pgsa_check u_pgsa_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (items.valid),
    .in_ready       (items.ready),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .out_read_value (results.read_value),
    .out_status     (results.status)
);

// ===== bench/point_gradient_scatter_add_tb.sv =====
module point_gradient_scatter_add_tb;
    import pgsa_pkg::*;

    localparam int PTS_MAX     = 1024;
    localparam int CH_MAX      = 16;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic signed [ACC_W-1:0] read_value;
        logic [STATUS_W-1:0]     status;
    } grad_result_t;

    class grad_accum_board;
        logic signed [ACC_W-1:0] entries [PTS_MAX*CH_MAX];
        logic [NPOINTS_W-1:0]    num_points;
        logic [NCHANNELS_W-1:0]  num_channels;
        grad_result_t            due_results [$];
        int                      errors;

        function new();
            foreach (entries[i])
            begin
                entries[i] = '0;
            end
            num_points   = NUM_POINTS_RST;
            num_channels = NUM_CHANNELS_RST;
            errors       = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_NUM_POINTS)
            begin
                num_points = data[NPOINTS_W-1:0];
            end
            else
            begin
                num_channels = data[NCHANNELS_W-1:0];
            end
        endfunction

        function int points_in_use();
            return (num_points > PTS_MAX) ? PTS_MAX : int'(num_points);
        endfunction

        function int channels_in_use();
            return (num_channels > CH_MAX) ? CH_MAX : int'(num_channels);
        endfunction

        function void note_item(logic [FUNC_W-1:0] func, logic [CHANNEL_W-1:0] ch,
                                logic signed [POINT_W-1:0] pt,
                                logic signed [GRAD_W-1:0] grad);
            int                  addr;
            logic signed [ACC_W:0] sum;
            grad_result_t        r;
            r.read_value = '0;
            r.status     = ST_OK;
            if (int'(ch) >= channels_in_use())
            begin
                r.status = ST_BAD_CHANNEL;
            end
            else if (pt < 0 || int'(pt) >= points_in_use())
            begin
                r.status = ST_BAD_POINT;
            end
            else
            begin
                addr = int'(ch) * PTS_MAX + int'(pt);
                if (func == FN_READ)
                begin
                    r.read_value  = entries[addr];
                    entries[addr] = '0;
                end
                else
                begin
                    sum = entries[addr] + grad;
                    if (sum > ACC_MAX)
                    begin
                        sum      = ACC_MAX;
                        r.status = ST_SATURATED;
                    end
                    else if (sum < ACC_MIN)
                    begin
                        sum      = ACC_MIN;
                        r.status = ST_SATURATED;
                    end
                    entries[addr] = sum[ACC_W-1:0];
                end
            end
            due_results.push_back(r);
        endfunction

        function void check_result(logic signed [ACC_W-1:0] value,
                                   logic [STATUS_W-1:0] status);
            grad_result_t want;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, read_value %h status %0d",
                         $time, value, status);
                return;
            end
            want = due_results.pop_front();
            if (value !== want.read_value)
            begin
                errors++;
                $display("%0t: read_value expected %h actual %h",
                         $time, want.read_value, value);
            end
            if (status !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, status);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pgsa_in_if  items_if ();
    pgsa_out_if results_if ();

    grad_accum_board board;
    bit              src_calm;
    bit              full_rate;

    point_gradient_scatter_add #(
        .MAX_POINTS   (PTS_MAX),
        .MAX_CHANNELS (CH_MAX)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items_if),
        .results   (results_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("point_gradient_scatter_add test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
            board.check_result(results_if.read_value, results_if.status);
    end

    // result-side backpressure
    initial
    begin
        int  stall_left;
        int  tick;
        int  pick;
        bit  calm;
        stall_left = 0;
        tick       = 0;
        calm       = 1'b0;
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 128 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (full_rate || calm)
            begin
                results_if.ready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                results_if.ready = 1'b0;
            end
            else
            begin
                results_if.ready = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    stall_left = $urandom_range(1, 3);
                else if (pick < 23)
                    stall_left = $urandom_range(8, 40);
            end
        end
    end

    task automatic send_item(logic [FUNC_W-1:0] func, logic [CHANNEL_W-1:0] ch,
                             logic signed [POINT_W-1:0] pt,
                             logic signed [GRAD_W-1:0] grad);
        int gap;
        int pick;
        gap = 0;
        if (!src_calm)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                gap = $urandom_range(1, 3);
            else if (pick < 28)
                gap = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            items_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        items_if.valid       = 1'b1;
        items_if.func        = func;
        items_if.channel     = ch;
        items_if.point_index = pt;
        items_if.grad_value  = grad;
        @(posedge clk);
        while (!items_if.ready) @(posedge clk);
        board.note_item(func, ch, pt, grad);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        items_if.valid = 1'b0;
        while (board.due_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        board.set_reg(idx, value[CFG_DATA_W-1:0]);
    endtask

    function automatic logic signed [GRAD_W-1:0] pick_grad();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $urandom;
        else if (pick < 70)
            return $signed($urandom_range(0, 2000)) - 1000;
        else if (pick < 78)
            return 32'sh7FFFFFFF;
        else if (pick < 85)
            return 32'sh80000000;
        else
            return $urandom | 32'h4000_0000;
    endfunction

    task automatic random_item(int win_base, int win_len);
        int                        pick;
        int                        np;
        int                        nc;
        logic [FUNC_W-1:0]         func;
        logic [CHANNEL_W-1:0]      ch;
        logic signed [POINT_W-1:0] pt;
        np   = board.points_in_use();
        nc   = board.channels_in_use();
        func = ($urandom_range(0, 99) < 25) ? FN_READ : FN_ACCUM;
        ch   = CHANNEL_W'($urandom);
        pt   = POINT_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70 && np > 0 && nc > 0)
        begin
            ch = CHANNEL_W'($urandom_range(0, nc - 1));
            if ($urandom_range(0, 4) == 0)
                pt = POINT_W'($urandom_range(0, np - 1));
            else
                pt = POINT_W'((win_base + $urandom_range(0, win_len - 1)) % np);
        end
        else if (pick < 85)
        begin
            // just past either end of the point range
            if ($urandom_range(0, 1) == 1)
                pt = POINT_W'(np + $urandom_range(0, 3));
            else
                pt = POINT_W'(-$signed($urandom_range(1, 4)));
            if (nc < CH_MAX && $urandom_range(0, 3) == 0)
                ch = CHANNEL_W'(nc);
        end
        send_item(func, ch, pt, pick_grad());
    endtask

    initial
    begin
        int win_base;
        int win_len;
        board                = new();
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_NUM_POINTS;
        cfg_data             = '0;
        items_if.valid       = 1'b0;
        items_if.func        = FN_ACCUM;
        items_if.channel     = '0;
        items_if.point_index = '0;
        items_if.grad_value  = '0;
        src_calm             = 1'b0;
        full_rate            = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes of the fields at reset config
        send_item(FN_ACCUM, 0, 0, 32'sh7FFFFFFF);
        send_item(FN_ACCUM, 0, 0, 32'sh80000000);
        send_item(FN_READ, 0, 0, 32'sh12345678);
        send_item(FN_ACCUM, 15, 1023, 1);
        send_item(FN_READ, 15, 1023, 0);
        send_item(FN_READ, 15, 1023, 0);
        send_item(FN_ACCUM, 2, -1, 5);
        send_item(FN_ACCUM, 2, 16'sh8000, 5);
        send_item(FN_READ, 2, 16'sh7FFF, 0);
        send_item(FN_ACCUM, 2, 1024, 5);
        send_item(FN_ACCUM, 1, 5, 32'sh00010000);

        // rejected read must leave the entry alone
        wait_drained();
        write_reg(REG_NUM_POINTS, 5);
        send_item(FN_READ, 1, 5, 0);
        send_item(FN_ACCUM, 1, 4, -2);

        // channel fault wins over point fault
        wait_drained();
        write_reg(REG_NUM_CHANNELS, 1);
        send_item(FN_ACCUM, 1, 0, 3);
        send_item(FN_READ, 15, -1, 0);
        send_item(FN_ACCUM, 0, 4, 7);

        wait_drained();
        write_reg(REG_NUM_POINTS, 0);
        write_reg(REG_NUM_CHANNELS, 0);
        send_item(FN_ACCUM, 0, 0, 1);
        wait_drained();
        write_reg(REG_NUM_CHANNELS, 16);
        send_item(FN_READ, 0, 0, 0);

        // registers above the parameters
        wait_drained();
        write_reg(REG_NUM_POINTS, 2047);
        write_reg(REG_NUM_CHANNELS, 31);
        send_item(FN_READ, 1, 5, 0);
        send_item(FN_ACCUM, 15, 1024, 1);
        send_item(FN_READ, 1, 4, 0);
        send_item(FN_READ, 0, 4, 0);

        // back-to-back large updates to one entry at full rate
        wait_drained();
        write_reg(REG_NUM_POINTS, 1024);
        write_reg(REG_NUM_CHANNELS, 16);
        full_rate = 1'b1;
        src_calm  = 1'b1;
        repeat (40) send_item(FN_ACCUM, 3, 7, 32'sh7FFFFFFF);
        send_item(FN_READ, 3, 7, 0);
        repeat (40) send_item(FN_ACCUM, 3, 7, 32'sh80000000);
        send_item(FN_READ, 3, 7, 0);
        full_rate = 1'b0;
        src_calm  = 1'b0;

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    write_reg(REG_NUM_POINTS, 1024);
                    write_reg(REG_NUM_CHANNELS, 16);
                end
                1:
                begin
                    write_reg(REG_NUM_POINTS, 1);
                    write_reg(REG_NUM_CHANNELS, 1);
                end
                2:
                begin
                    write_reg(REG_NUM_POINTS, 2047);
                    write_reg(REG_NUM_CHANNELS, 31);
                end
                default:
                begin
                    write_reg(REG_NUM_POINTS, $urandom_range(2, 1023));
                    write_reg(REG_NUM_CHANNELS, $urandom_range(2, 15));
                end
            endcase
            win_base = 0;
            win_len  = 1;
            for (int n = 0; n < 280; n++)
            begin
                if (n % 50 == 0)
                begin
                    src_calm = ($urandom_range(0, 3) == 0);
                    win_base = $urandom_range(0, PTS_MAX - 1);
                    win_len  = $urandom_range(1, 8);
                end
                random_item(win_base, win_len);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.due_results.size() == 0)
        begin
            $display("point_gradient_scatter_add test passed");
        end
        else
        begin
            $display("point_gradient_scatter_add test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pgsa_pkg.sv
rtl/pgsa_in_if.sv
rtl/pgsa_out_if.sv
rtl/pgsa_ram.sv
rtl/pgsa_sat_add.sv
rtl/point_gradient_scatter_add.sv
rtl/pgsa_check.sv
bench/point_gradient_scatter_add_tb.sv
